[hdl/node_sequence_gossip_table_defines.svh]
// Assertion macros for the gossip table RTL.
`ifndef NODE_SEQUENCE_GOSSIP_TABLE_DEFINES_SVH
`define NODE_SEQUENCE_GOSSIP_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define GSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gossip table check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define GSP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gossip table check failed");
`else
`define GSP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GSP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/gsp_pkg.sv]
// Types, codes and sizes shared by the gossip table modules.
`default_nettype none
package gsp_pkg;
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int MAX_RESULTS = 15;
  localparam int MAX_ENTRIES = MAX_RESULTS - 1;
  localparam int COUNT_BYTES = 1;
  localparam int ENTRY_BYTES = 7;

  // Input kinds.
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_RECV  = 2'd1;
  localparam logic [1:0] KIND_BUMP  = 2'd2;
  localparam logic [1:0] KIND_BUILD = 2'd3;

  // Record kinds.
  localparam logic [1:0] REC_STATUS = 2'd0;
  localparam logic [1:0] REC_ENTRY  = 2'd1;
  localparam logic [1:0] REC_COUNT  = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_STALE   = 3'd1;
  localparam logic [2:0] ST_OWN_ID  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ID_ZERO = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_ID   = 2'd0;
  localparam logic [1:0] CFG_MAX_LIFE = 2'd1;
  localparam logic [1:0] CFG_LIMIT    = 2'd2;

  // One table slot.
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] seq;
    logic [7:0]  lt;
  } slot_t;
endpackage
`default_nettype wire

[hdl/gsp_cell.sv]
// One slot cell of the rotating table chain.
`default_nettype none
module gsp_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          shift,
  input  wire gsp_pkg::slot_t d,
  output gsp_pkg::slot_t     q
);
  // Take the next cell's slot (the write-back, for the tail) whenever the chain advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end
endmodule
`default_nettype wire

[hdl/node_sequence_gossip_table.sv]
// Gossip table: node id / sequence / lifetime slots with find-or-allocate.
// Usage: one input channel (in_valid / in_stall) carries a command word of
// kind, node_id, seq and ttl; one output channel (out_valid / out_stall)
// returns result words. Init, receive and bump give one status word; build
// gives the payload entry words and then a count word; last marks the final
// word of each command. The slots sit in a ring of cells that, during a
// pass, advances one slot per cycle past a single head controller unless a
// stalled output freezes it. Init takes one pass. Receive, bump and build
// take a search pass, a decision state and an update pass; receive and bump
// skip the update pass when the table is full, and receive of the own id or
// of id zero skips both passes. Build adds an own-entry step when its slot
// is found. The ring pass is what sets the rate; one command is worked on at
// a time and in_stall stays high until its final word has been handed to the
// output register. A stalled output holds its word and freezes the ring when
// the next entry word is due. Reset empties all slots, clears the sequence
// counter, loads the register defaults (own id 1, lifetime 5, limit 100) and
// drops out_valid. Configuration must be written by the user through cfg_we,
// cfg_index and cfg_data while the block is idle, which it does not enforce.
`default_nettype none
`include "node_sequence_gossip_table_defines.svh"
module node_sequence_gossip_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] node_id,
  input  wire logic [31:0] seq,
  input  wire logic [7:0]  ttl,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       record_kind,
  output logic [2:0]       status,
  output logic [15:0]      entry_id,
  output logic [31:0]      entry_seq,
  output logic [7:0]       entry_lifetime,
  output logic [4:0]       entry_count,
  output logic             last
);
  localparam logic [gsp_pkg::IDX_W-1:0] LAST_IDX =
    gsp_pkg::IDX_W'(gsp_pkg::TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_FIND, S_DECIDE, S_OWN, S_UPDATE, S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] own_id;
  logic [7:0]  max_life;
  logic [6:0]  limit;

  // Latched command.
  logic [1:0]  op;
  logic [15:0] rx_id;
  logic [31:0] rx_seq;
  logic [7:0]  rx_ttl;

  // Pass bookkeeping.
  logic [gsp_pkg::IDX_W-1:0] idx;
  logic                      match_found;
  logic [gsp_pkg::IDX_W-1:0] match_idx;
  logic [31:0]               match_seq;
  logic                      empty_found;
  logic [gsp_pkg::IDX_W-1:0] empty_idx;
  logic [31:0]               empty_seq;
  logic [2:0]                st;
  logic [4:0]                n;
  logic [7:0]                len;
  logic                      stop;
  logic [31:0]               own_counter;

  // Ring of slot cells; cell 0 is the head seen by the controller.
  gsp_pkg::slot_t ring [gsp_pkg::TABLE_ENTRIES];
  gsp_pkg::slot_t head;
  gsp_pkg::slot_t wb;
  logic           shift_en;

  for (genvar i = 0; i < gsp_pkg::TABLE_ENTRIES; i++) begin : g_cell
    if (i == gsp_pkg::TABLE_ENTRIES - 1) begin : g_tail
      gsp_cell u_cell (.clk(clk), .rst(rst), .shift(shift_en), .d(wb), .q(ring[i]));
    end else begin : g_body
      gsp_cell u_cell (.clk(clk), .rst(rst), .shift(shift_en), .d(ring[i+1]), .q(ring[i]));
    end
  end

  assign head = ring[0];

  // Head decode.
  logic [15:0]               key;
  logic                      pass_end;
  logic                      target_found;
  logic [gsp_pkg::IDX_W-1:0] target_idx;
  logic [31:0]               target_seq;
  logic                      at_target;
  logic                      seq_newer;
  logic                      other_live;
  logic                      room;
  logic                      emit_cand;
  logic                      emit;
  logic                      out_free;
  logic                      out_load;

  always_comb begin
    key          = (op == gsp_pkg::KIND_RECV) ? rx_id : own_id;
    pass_end     = (idx == LAST_IDX);
    target_found = match_found || empty_found;
    target_idx   = match_found ? match_idx : empty_idx;
    target_seq   = match_found ? match_seq : empty_seq;
    at_target    = target_found && (idx == target_idx);
    seq_newer    = rx_seq > head.seq;
    other_live   = (head.id != 16'd0) && (head.id != own_id) && (head.lt > 8'd1);
    room         = ((len + 8'(gsp_pkg::ENTRY_BYTES)) <= {1'b0, limit}) &&
                   (n < 5'(gsp_pkg::MAX_ENTRIES));
    emit_cand    = (state == S_UPDATE) && (op == gsp_pkg::KIND_BUILD) && !stop &&
                   other_live;
    out_free     = !out_valid || !out_stall;
    emit         = emit_cand && room && out_free;
    out_load     = ((state == S_OWN) || (state == S_FINISH)) ? out_free : emit;
  end

  // The ring advances on every pass cycle, but waits for a free output
  // register when an entry word is due.
  always_comb begin
    case (state)
      S_INIT, S_FIND: shift_en = 1'b1;
      S_UPDATE:       shift_en = !(emit_cand && room && !out_free);
      default:        shift_en = 1'b0;
    endcase
  end

  // Write-back of the head slot into the tail of the ring.
  always_comb begin
    wb = head;
    case (state)
      S_INIT: begin
        wb = '0;
        if (idx == '0) begin
          wb.id  = own_id;
          wb.seq = 32'd1;
          wb.lt  = max_life;
        end
      end
      S_UPDATE: begin
        if (at_target) begin
          case (op)
            gsp_pkg::KIND_RECV: begin
              wb.id = rx_id;
              if (seq_newer) begin
                wb.seq = rx_seq;
                wb.lt  = rx_ttl;
              end
            end
            gsp_pkg::KIND_BUMP: begin
              wb.id  = own_id;
              wb.seq = own_counter + 32'd1;
              wb.lt  = max_life;
            end
            gsp_pkg::KIND_BUILD: begin
              wb.id = own_id;
              wb.lt = max_life;
            end
            default: wb = head;
          endcase
        end
      end
      default: wb = head;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // Controller state, counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      own_id      <= 16'd1;
      max_life    <= 8'd5;
      limit       <= 7'd100;
      own_counter <= '0;
      idx         <= '0;
      match_found <= 1'b0;
      empty_found <= 1'b0;
      stop        <= 1'b0;
      n           <= '0;
      len         <= 8'(gsp_pkg::COUNT_BYTES);
      out_valid   <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        case (cfg_index)
          gsp_pkg::CFG_OWN_ID:   own_id   <= cfg_data;
          gsp_pkg::CFG_MAX_LIFE: max_life <= cfg_data[7:0];
          gsp_pkg::CFG_LIMIT:    limit    <= cfg_data[6:0];
          default: ;
        endcase
      end

      // A new word is loaded, or the held word leaves when the receiver takes it.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op          <= kind;
            rx_id       <= node_id;
            rx_seq      <= seq;
            rx_ttl      <= ttl;
            idx         <= '0;
            match_found <= 1'b0;
            empty_found <= 1'b0;
            stop        <= 1'b0;
            n           <= '0;
            len         <= 8'(gsp_pkg::COUNT_BYTES);
            case (kind)
              gsp_pkg::KIND_INIT: state <= S_INIT;
              gsp_pkg::KIND_RECV: begin
                if (node_id == own_id) begin
                  st    <= gsp_pkg::ST_OWN_ID;
                  state <= S_FINISH;
                end else if (node_id == 16'd0) begin
                  st    <= gsp_pkg::ST_ID_ZERO;
                  state <= S_FINISH;
                end else begin
                  state <= S_FIND;
                end
              end
              default: state <= S_FIND;
            endcase
          end
        end

        // Clear every slot and install the own node in slot zero.
        S_INIT: begin
          idx <= pass_end ? '0 : idx + 1'b1;
          if (pass_end) begin
            own_counter <= 32'd1;
            st          <= gsp_pkg::ST_UPDATED;
            state       <= S_FINISH;
          end
        end

        // Search pass: first slot holding the key and first empty slot.
        S_FIND: begin
          if (!match_found && (head.id == key)) begin
            match_found <= 1'b1;
            match_idx   <= idx;
            match_seq   <= head.seq;
          end
          if (!empty_found && (head.id == 16'd0)) begin
            empty_found <= 1'b1;
            empty_idx   <= idx;
            empty_seq   <= head.seq;
          end
          idx <= pass_end ? '0 : idx + 1'b1;
          if (pass_end) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          st <= target_found ? gsp_pkg::ST_UPDATED : gsp_pkg::ST_FULL;
          if (op == gsp_pkg::KIND_BUILD) begin
            state <= target_found ? S_OWN : S_UPDATE;
          end else begin
            state <= target_found ? S_UPDATE : S_FINISH;
          end
        end

        // Own entry goes out first at full lifetime.
        S_OWN: begin
          if (out_free) begin
            record_kind    <= gsp_pkg::REC_ENTRY;
            status         <= gsp_pkg::ST_UPDATED;
            entry_id       <= own_id;
            entry_seq      <= target_seq;
            entry_lifetime <= max_life;
            entry_count    <= '0;
            last           <= 1'b0;
            n              <= 5'd1;
            len            <= 8'(gsp_pkg::COUNT_BYTES + gsp_pkg::ENTRY_BYTES);
            state          <= S_UPDATE;
          end
        end

        // Update pass: modify the target slot; for build, emit other live entries.
        S_UPDATE: begin
          if (shift_en) begin
            if (at_target) begin
              case (op)
                gsp_pkg::KIND_RECV: begin
                  st <= seq_newer ? gsp_pkg::ST_UPDATED : gsp_pkg::ST_STALE;
                end
                gsp_pkg::KIND_BUMP: own_counter <= own_counter + 32'd1;
                default: ;
              endcase
            end
            if (emit_cand && !room) begin
              stop <= 1'b1;
            end
            if (emit) begin
              record_kind    <= gsp_pkg::REC_ENTRY;
              status         <= gsp_pkg::ST_UPDATED;
              entry_id       <= head.id;
              entry_seq      <= head.seq;
              entry_lifetime <= head.lt - 8'd1;
              entry_count    <= '0;
              last           <= 1'b0;
              n              <= n + 5'd1;
              len            <= len + 8'(gsp_pkg::ENTRY_BYTES);
            end
            idx <= pass_end ? '0 : idx + 1'b1;
            if (pass_end) begin
              state <= S_FINISH;
            end
          end
        end

        // Final status or count word.
        S_FINISH: begin
          if (out_free) begin
            status         <= st;
            entry_id       <= '0;
            entry_seq      <= '0;
            entry_lifetime <= '0;
            last           <= 1'b1;
            if (op == gsp_pkg::KIND_BUILD) begin
              record_kind <= gsp_pkg::REC_COUNT;
              entry_count <= n;
            end else begin
              record_kind <= gsp_pkg::REC_STATUS;
              entry_count <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted command leaves the block busy in the cycle after it is taken.
  `GSP_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // Every pass leaves the ring aligned with slot zero at the head.
  `GSP_ASSERT_IMP(a_idle_aligned, clk, rst, state == S_IDLE, idx == '0)
  // The entry count never exceeds the entry cap, MAX_ENTRIES.
  `GSP_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, n <= 5'(gsp_pkg::MAX_ENTRIES))
  // Entry words are never the final word of a command.
  `GSP_ASSERT_IMP(a_entry_not_last, clk, rst,
    out_valid && (record_kind == gsp_pkg::REC_ENTRY), !last)
endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the node sequence gossip table.
`timescale 1ns / 1ps
module tb;
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POOL_SIZE      = 20;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_COMMANDS = 44;

  // One command word as the sender presents it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] node_id;
    logic [31:0] seq;
    logic [7:0]  ttl;
    logic        drain_first;
  } command_t;

  // One result word as the block returns it.
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  status;
    logic [15:0] entry_id;
    logic [31:0] entry_seq;
    logic [7:0]  entry_lifetime;
    logic [4:0]  entry_count;
    logic        last;
  } record_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = '0;
  logic [15:0] node_id = '0;
  logic [31:0] seq = '0;
  logic [7:0]  ttl = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  record_kind;
  logic [2:0]  status;
  logic [15:0] entry_id;
  logic [31:0] entry_seq;
  logic [7:0]  entry_lifetime;
  logic [4:0]  entry_count;
  logic        last;

  node_sequence_gossip_table dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .node_id(node_id), .seq(seq), .ttl(ttl),
    .out_valid(out_valid), .out_stall(out_stall),
    .record_kind(record_kind), .status(status), .entry_id(entry_id),
    .entry_seq(entry_seq), .entry_lifetime(entry_lifetime),
    .entry_count(entry_count), .last(last)
  );

  always #2 clk = ~clk;

  // Shadow copy of the table and the registers.
  gsp_pkg::slot_t gossip_slots [gsp_pkg::TABLE_ENTRIES];
  logic [31:0] own_seq = '0;
  logic [15:0] cfg_own = 16'd1;
  logic [7:0]  cfg_max_life = 8'd5;
  logic [6:0]  cfg_limit = 7'd100;

  command_t    pending_commands [$];
  record_t     expected_records [$];
  command_t    presented;
  logic [15:0] node_pool [POOL_SIZE];

  logic        calm = 1'b0;
  logic        drained = 1'b1;
  logic        took;
  int          sender_gap = 0;
  int          receiver_hold = 0;
  int          idle_cycles = 0;
  int          errors = 0;
  int          words_checked = 0;
  int          entries_checked = 0;
  int          kinds_seen [4] = '{0, 0, 0, 0};
  int          phase;

  initial begin
    for (int i = 0; i < gsp_pkg::TABLE_ENTRIES; i++) gossip_slots[i] = '0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Find the slot that holds an id, else claim the first empty one.
  function automatic int find_or_claim(input logic [15:0] id);
    int i;
    for (i = 0; i < gsp_pkg::TABLE_ENTRIES; i++)
      if (gossip_slots[i].id == id) return i;
    for (i = 0; i < gsp_pkg::TABLE_ENTRIES; i++)
      if (gossip_slots[i].id == 16'd0) begin
        gossip_slots[i].id = id;
        return i;
      end
    return -1;
  endfunction

  function automatic void expect_record(input logic [1:0] rk, input logic [2:0] st,
                                        input logic [15:0] id, input logic [31:0] sq,
                                        input logic [7:0] lt, input logic [4:0] cnt,
                                        input logic lst);
    record_t r;
    r.record_kind    = rk;
    r.status         = st;
    r.entry_id       = id;
    r.entry_seq      = sq;
    r.entry_lifetime = lt;
    r.entry_count    = cnt;
    r.last           = lst;
    expected_records.push_back(r);
  endfunction

  // Apply one accepted command to the shadow table and queue its result words.
  function automatic void advance_table(input command_t c);
    int s;
    int i;
    int n;
    int nbytes;
    logic [7:0] lt;
    logic [2:0] st;
    kinds_seen[c.kind]++;
    case (c.kind)
      gsp_pkg::KIND_INIT: begin
        for (i = 0; i < gsp_pkg::TABLE_ENTRIES; i++) gossip_slots[i] = '0;
        s = find_or_claim(cfg_own);
        if (s >= 0) begin
          gossip_slots[s].seq = 32'd1;
          gossip_slots[s].lt  = cfg_max_life;
        end
        own_seq = 32'd1;
        expect_record(gsp_pkg::REC_STATUS, gsp_pkg::ST_UPDATED, '0, '0, '0, '0, 1'b1);
      end
      gsp_pkg::KIND_RECV: begin
        if (c.node_id == cfg_own) st = gsp_pkg::ST_OWN_ID;
        else if (c.node_id == 16'd0) st = gsp_pkg::ST_ID_ZERO;
        else begin
          s = find_or_claim(c.node_id);
          if (s < 0) st = gsp_pkg::ST_FULL;
          else if (c.seq > gossip_slots[s].seq) begin
            gossip_slots[s].seq = c.seq;
            gossip_slots[s].lt  = c.ttl;
            st = gsp_pkg::ST_UPDATED;
          end else st = gsp_pkg::ST_STALE;
        end
        expect_record(gsp_pkg::REC_STATUS, st, '0, '0, '0, '0, 1'b1);
      end
      gsp_pkg::KIND_BUMP: begin
        st = gsp_pkg::ST_FULL;
        s = find_or_claim(cfg_own);
        if (s >= 0) begin
          own_seq = own_seq + 32'd1;
          gossip_slots[s].seq = own_seq;
          gossip_slots[s].lt  = cfg_max_life;
          st = gsp_pkg::ST_UPDATED;
        end
        expect_record(gsp_pkg::REC_STATUS, st, '0, '0, '0, '0, 1'b1);
      end
      default: begin
        // Own entry goes first and is not held to the byte budget.
        n = 0;
        nbytes = gsp_pkg::COUNT_BYTES;
        st = gsp_pkg::ST_FULL;
        s = find_or_claim(cfg_own);
        if (s >= 0) begin
          gossip_slots[s].lt = cfg_max_life;
          expect_record(gsp_pkg::REC_ENTRY, gsp_pkg::ST_UPDATED, gossip_slots[s].id,
                        gossip_slots[s].seq, gossip_slots[s].lt, '0, 1'b0);
          n++;
          nbytes += gsp_pkg::ENTRY_BYTES;
          st = gsp_pkg::ST_UPDATED;
        end
        // Other live entries, aged by one hop, until budget or cap runs out.
        for (i = 0; i < gsp_pkg::TABLE_ENTRIES; i++) begin
          if (gossip_slots[i].id == 16'd0 || gossip_slots[i].id == cfg_own) continue;
          lt = gossip_slots[i].lt;
          if (lt > 8'd0) lt = lt - 8'd1;
          if (lt == 8'd0) continue;
          if (nbytes + gsp_pkg::ENTRY_BYTES > int'(cfg_limit)) break;
          if (n >= gsp_pkg::MAX_ENTRIES) break;
          expect_record(gsp_pkg::REC_ENTRY, gsp_pkg::ST_UPDATED, gossip_slots[i].id,
                        gossip_slots[i].seq, lt, '0, 1'b0);
          n++;
          nbytes += gsp_pkg::ENTRY_BYTES;
        end
        expect_record(gsp_pkg::REC_COUNT, st, '0, '0, '0, n[4:0], 1'b1);
      end
    endcase
  endfunction

  // Sender: present queued command words with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      sender_gap = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) advance_table(presented);
      if (took || !in_valid) begin
        if (sender_gap > 0) begin
          sender_gap--;
          in_valid <= 1'b0;
        end else if (pending_commands.size() > 0 &&
                     !(pending_commands[0].drain_first && (took || !drained))) begin
          presented = pending_commands.pop_front();
          in_valid <= 1'b1;
          kind     <= presented.kind;
          node_id  <= presented.node_id;
          seq      <= presented.seq;
          ttl      <= presented.ttl;
          sender_gap = calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Sampled away from the active edge so the sender sees a settled value.
  always @(negedge clk) drained <= (expected_records.size() == 0);

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endtask

  // Receiver: random stalls, each accepted result word checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      receiver_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_records.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual kind %0d status %0d",
                   $time, record_kind, status);
        end else begin
          check_field("record_kind", 32'(expected_records[0].record_kind),
                      32'(record_kind));
          check_field("status", 32'(expected_records[0].status), 32'(status));
          check_field("entry_id", 32'(expected_records[0].entry_id), 32'(entry_id));
          check_field("entry_seq", expected_records[0].entry_seq, entry_seq);
          check_field("entry_lifetime", 32'(expected_records[0].entry_lifetime),
                      32'(entry_lifetime));
          check_field("entry_count", 32'(expected_records[0].entry_count),
                      32'(entry_count));
          check_field("last", 32'(expected_records[0].last), 32'(last));
          if (expected_records[0].record_kind == gsp_pkg::REC_ENTRY) entries_checked++;
          void'(expected_records.pop_front());
          words_checked++;
        end
      end
      if (receiver_hold > 0) begin
        receiver_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) receiver_hold = pick_gap();
      end
    end
  end

  // Stop the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_command(input logic [1:0] k, input logic [15:0] id,
                              input logic [31:0] sq, input logic [7:0] lt,
                              input logic drain);
    command_t c;
    c.kind        = k;
    c.node_id     = id;
    c.seq         = sq;
    c.ttl         = lt;
    c.drain_first = drain;
    pending_commands.push_back(c);
  endtask

  // Write all three registers while the block is idle.
  task automatic set_config(input logic [15:0] own, input logic [7:0] life,
                            input logic [6:0] limit);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= gsp_pkg::CFG_OWN_ID;
    cfg_data  <= own;
    @(posedge clk);
    cfg_own = own;
    cfg_index <= gsp_pkg::CFG_MAX_LIFE;
    cfg_data  <= {8'd0, life};
    @(posedge clk);
    cfg_max_life = life;
    cfg_index <= gsp_pkg::CFG_LIMIT;
    cfg_data  <= {9'd0, limit};
    @(posedge clk);
    cfg_limit = limit;
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every queued word has been sent and answered, then let the block settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_commands.size() != 0 || in_valid || expected_records.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random commands: mostly receives of a small id pool so that slots are reused,
  // go stale and run out, with inits, bumps and builds mixed in.
  task automatic queue_random(input int count);
    int r;
    logic [1:0]  k;
    logic [15:0] id;
    logic [31:0] sq;
    logic [7:0]  lt;
    for (int j = 0; j < count; j++) begin
      r = $urandom_range(0, 99);
      if (r < 6) k = gsp_pkg::KIND_INIT;
      else if (r < 62) k = gsp_pkg::KIND_RECV;
      else if (r < 78) k = gsp_pkg::KIND_BUMP;
      else k = gsp_pkg::KIND_BUILD;
      r = $urandom_range(0, 99);
      if (r < 4) id = 16'd0;
      else if (r < 10) id = cfg_own;
      else if (r < 85) id = node_pool[$urandom_range(0, POOL_SIZE - 1)];
      else id = 16'($urandom());
      r = $urandom_range(0, 99);
      if (r < 50) sq = $urandom_range(0, 40);
      else if (r < 70) sq = $urandom_range(0, 3);
      else if (r < 92) sq = $urandom();
      else sq = 32'hFFFF_FFFF;
      lt = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 4)) :
                                          8'($urandom_range(0, 255));
      push_command(k, id, sq, lt, $urandom_range(0, 99) < 4);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset register values.
    push_command(gsp_pkg::KIND_BUILD, 16'd0, 32'd0, 8'd0, 1'b0);
    push_command(gsp_pkg::KIND_BUMP, 16'd0, 32'd0, 8'd0, 1'b0);
    push_command(gsp_pkg::KIND_INIT, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    push_command(gsp_pkg::KIND_RECV, 16'd1, 32'd9, 8'd3, 1'b0);
    push_command(gsp_pkg::KIND_RECV, 16'd0, 32'd9, 8'd3, 1'b0);
    push_command(gsp_pkg::KIND_RECV, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    push_command(gsp_pkg::KIND_RECV, 16'hFFFF, 32'd5, 8'd9, 1'b0);
    push_command(gsp_pkg::KIND_RECV, 16'd2, 32'd0, 8'd3, 1'b0);
    push_command(gsp_pkg::KIND_RECV, 16'd3, 32'd1, 8'd1, 1'b0);
    push_command(gsp_pkg::KIND_RECV, 16'd4, 32'd7, 8'd0, 1'b0);
    push_command(gsp_pkg::KIND_RECV, 16'd5, 32'h8000_0000, 8'd2, 1'b0);
    // Fill the remaining slots; the last one finds the table full.
    for (int j = 0; j < 11; j++)
      push_command(gsp_pkg::KIND_RECV, 16'(32'h0100 + j), 32'(32'd1 + j),
                   8'(32'h40 + j), 1'b0);
    push_command(gsp_pkg::KIND_BUMP, 16'd0, 32'd0, 8'd0, 1'b0);
    push_command(gsp_pkg::KIND_BUILD, 16'd0, 32'd0, 8'd0, 1'b1);
    push_command(gsp_pkg::KIND_RECV, 16'h0AAA, 32'd3, 8'd3, 1'b0);
    wait_idle();

    // Random phases, each under its own register setting.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int j = 0; j < POOL_SIZE; j++) node_pool[j] = 16'($urandom_range(1, 16'hFFFF));
      case (phase)
        0: set_config(16'hFFFF, 8'd255, 7'd127);
        1: set_config(node_pool[3], 8'd1, 7'd8);
        2: set_config(16'h0000, 8'd0, 7'd0);
        3: set_config(16'($urandom()), 8'($urandom_range(1, 255)), 7'd15);
        4: set_config(16'd1, 8'd5, 7'd100);
        default: set_config(node_pool[$urandom_range(0, POOL_SIZE - 1)],
                            8'($urandom_range(0, 255)), 7'($urandom_range(8, 127)));
      endcase
      calm = (phase % 3 == 1);
      queue_random(PHASE_COMMANDS);
      wait_idle();
    end

    if (expected_records.size() != 0) begin
      errors += expected_records.size();
      $display("%0t: %0d result words never arrived", $time, expected_records.size());
    end
    $display("Ran %0d commands (init %0d, receive %0d, bump %0d, build %0d) under %0d settings.",
             kinds_seen[0] + kinds_seen[1] + kinds_seen[2] + kinds_seen[3], kinds_seen[0],
             kinds_seen[1], kinds_seen[2], kinds_seen[3], RANDOM_PHASES + 1);
    $display("Compared %0d result words, %0d of them payload entries, with %0d errors.",
             words_checked, entries_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+hdl
hdl/gsp_pkg.sv
hdl/gsp_cell.sv
hdl/node_sequence_gossip_table.sv
bench/tb.sv
